// ----- hw/rtl/awb_pkg.sv -----
// ----------------------------------------------------------------------------
// awb_pkg
// Shared types and constants for the ARGB8888 weighted blend unit.
// ----------------------------------------------------------------------------
package awb_pkg;

    // Channel and operand widths
    localparam int CH_W      = 8;                 // one color channel
    localparam int NUM_LANES = 4;                 // B, G, R, A
    localparam int LANE_A    = 3;                 // lane that holds alpha
    localparam int WGT_W     = 16;                // weight input width
    localparam int DIV_W     = WGT_W + 1;         // weight sum width
    localparam int NUM_W     = CH_W + WGT_W + 1;  // sum of two products
    localparam int QUO_BITS  = CH_W;              // quotient never exceeds 255
    localparam int EXT_W     = NUM_W + QUO_BITS;  // divider compare width
    localparam int COLOR_W   = CH_W * NUM_LANES;

    // Pipeline: one multiply stage, one stage per quotient bit, one output stage
    localparam int NUM_STG   = QUO_BITS + 2;
    localparam int STG_OUT   = NUM_STG - 1;

    localparam logic [CH_W-1:0] CH_MAX = 8'hff;

    typedef enum logic {
        OP_MIX  = 1'b0,
        OP_OVER = 1'b1
    } blend_op_t;

    // Sideband that travels with each beat
    typedef struct packed {
        blend_op_t op;
        logic      zero;
    } blend_tag_t;

    // Per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NUM_STG-1:0] load;
    } pipe_ctl_t;

endpackage

// ----- hw/rtl/awb_ctrl.sv -----
// ----------------------------------------------------------------------------
// awb_ctrl
// Stage valid bits, per-stage ready chain and the sideband tag pipeline.
// A stage loads when it is empty or its successor moves on, so bubbles
// collapse and the front keeps filling while a result waits.
// ----------------------------------------------------------------------------
module awb_ctrl
    import awb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    output logic       pix_stall,
    input  blend_tag_t pix_tag,
    output logic       res_valid,
    input  logic       res_stall,
    output pipe_ctl_t  ctl,
    output blend_tag_t last_tag
);

    logic [NUM_STG-1:0] vld_reg;
    logic [NUM_STG-1:0] vld_next;
    logic [NUM_STG-1:0] rdy;
    blend_tag_t         tag_reg [0:QUO_BITS];

    // Ready chain from the output back to the input
    always_comb
    begin
        rdy[STG_OUT] = !vld_reg[STG_OUT] || !res_stall;
        for (int s = STG_OUT - 1; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    // Valid bits shift where the stage loads
    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = pix_valid;
        end
        for (int s = 1; s < NUM_STG; s++)
        begin
            if (rdy[s])
            begin
                vld_next[s] = vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Tag pipeline, stages 0 through the last divide stage
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            tag_reg[0] <= pix_tag;
        end
        for (int s = 1; s <= QUO_BITS; s++)
        begin
            if (rdy[s])
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign ctl.load  = rdy;
    assign pix_stall = !rdy[0];
    assign res_valid = vld_reg[STG_OUT];
    assign last_tag  = tag_reg[QUO_BITS];

endmodule

// ----- hw/rtl/awb_lane.sv -----
// ----------------------------------------------------------------------------
// awb_lane
// One channel lane: q = floor((p1*q1 + p2*q2) / dvs).
// A multiply stage, then a restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module awb_lane
    import awb_pkg::*;
(
    input  logic              clk,
    input  pipe_ctl_t         ctl,
    input  logic [CH_W-1:0]   p1,
    input  logic [WGT_W-1:0]  q1,
    input  logic [CH_W-1:0]   p2,
    input  logic [WGT_W-1:0]  q2,
    input  logic [DIV_W-1:0]  dvs,
    output logic [CH_W-1:0]   quo
);

    logic [NUM_W-1:0]    num_reg [0:QUO_BITS-1];
    logic [DIV_W-1:0]    den_reg [0:QUO_BITS-1];
    logic [QUO_BITS-1:0] quo_reg [1:QUO_BITS];
    logic [NUM_W-1:0]    num_next;

    // Multiply stage
    assign num_next = NUM_W'(p1) * NUM_W'(q1) + NUM_W'(p2) * NUM_W'(q2);

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            num_reg[0] <= num_next;
            den_reg[0] <= dvs;
        end
    end

    // Divide stages, most significant quotient bit first
    for (genvar k = 1; k <= QUO_BITS; k++)
    begin : g_div
        localparam int SH = QUO_BITS - k;
        logic [EXT_W-1:0] rem_ext;
        logic [EXT_W-1:0] trial_den;
        logic             take;

        assign rem_ext   = EXT_W'(num_reg[k-1]);
        assign trial_den = EXT_W'(den_reg[k-1]) << SH;
        assign take      = rem_ext >= trial_den;

        if (k < QUO_BITS)
        begin : g_rem
            logic [EXT_W-1:0] rem_next;
            assign rem_next = take ? rem_ext - trial_den : rem_ext;

            always_ff @(posedge clk)
            begin
                if (ctl.load[k])
                begin
                    num_reg[k] <= rem_next[NUM_W-1:0];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end

        if (k == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (ctl.load[k])
                begin
                    quo_reg[k] <= QUO_BITS'(take);
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (ctl.load[k])
                begin
                    quo_reg[k] <= {quo_reg[k-1][QUO_BITS-2:0], take};
                end
            end
        end
    end

    assign quo = quo_reg[QUO_BITS];

endmodule

// ----- hw/rtl/awb_merge.sv -----
// ----------------------------------------------------------------------------
// awb_merge
// Packs the lane quotients into one ARGB word, inverts alpha for the over
// operation and forces zero on an empty weight sum. Output register.
// ----------------------------------------------------------------------------
module awb_merge
    import awb_pkg::*;
(
    input  logic               clk,
    input  pipe_ctl_t          ctl,
    input  blend_tag_t         last_tag,
    input  logic [CH_W-1:0]    lane_quo [0:NUM_LANES-1],
    output logic [COLOR_W-1:0] blended_color,
    output logic               zero_weight
);

    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic               zero_reg;
    logic [CH_W-1:0]    alpha;

    // Over: lane A holds floor((255-a_orig)*(255-a_new)/255)
    assign alpha = (last_tag.op == OP_OVER) ? CH_MAX - lane_quo[LANE_A]
                                            : lane_quo[LANE_A];

    always_comb
    begin
        color_next = '0;
        if (!last_tag.zero)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                color_next[i*CH_W +: CH_W] = lane_quo[i];
            end
            color_next[LANE_A*CH_W +: CH_W] = alpha;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_OUT])
        begin
            color_reg <= color_next;
            zero_reg  <= last_tag.zero;
        end
    end

    assign blended_color = color_reg;
    assign zero_weight   = zero_reg;

endmodule

// ----- hw/rtl/argb_weighted_blend.sv -----
// ----------------------------------------------------------------------------
// argb_weighted_blend
// ARGB8888 pixel blend: weighted mix of two colors, or alpha over.
// Four channel lanes run side by side; a merge stage packs the result.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  pix     | pix_valid/pix_stall  | func, first_color, second_color,
//          |                      | first_weight, second_weight
//  res     | res_valid/res_stall  | blended_color, zero_weight
//
//  One beat per clock while res_stall is low; stages are a multiply stage,
//  eight divider stages at one quotient bit each, and the output register.
//  Each stage holds its beat only while its successor is full and held, so
//  pix_stall rises only when every stage is full and res_stall is high.
//  Reset clears the stage valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module argb_weighted_blend
    import awb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  logic               func,
    input  logic [COLOR_W-1:0] first_color,
    input  logic [COLOR_W-1:0] second_color,
    input  logic [WGT_W-1:0]   first_weight,
    input  logic [WGT_W-1:0]   second_weight,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [COLOR_W-1:0] blended_color,
    output logic               zero_weight
);

    blend_op_t        op;
    blend_tag_t       pix_tag;
    blend_tag_t       last_tag;
    pipe_ctl_t        ctl;
    logic [CH_W-1:0]  a_orig;
    logic [CH_W-1:0]  a_new;
    logic [DIV_W-1:0] wsum;
    logic [CH_W-1:0]  lane_quo [0:NUM_LANES-1];

    assign op     = blend_op_t'(func);
    assign a_orig = first_color[LANE_A*CH_W +: CH_W];
    assign a_new  = second_color[LANE_A*CH_W +: CH_W];
    assign wsum   = DIV_W'(first_weight) + DIV_W'(second_weight);

    assign pix_tag.op   = op;
    assign pix_tag.zero = (op == OP_MIX) && (wsum == '0);

    awb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_tag   (pix_tag),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .ctl       (ctl),
        .last_tag  (last_tag)
    );

    // Lane operand selection
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        logic [CH_W-1:0]  p1;
        logic [WGT_W-1:0] q1;
        logic [CH_W-1:0]  p2;
        logic [WGT_W-1:0] q2;
        logic [DIV_W-1:0] dvs;

        always_comb
        begin
            if (op == OP_MIX)
            begin
                p1  = first_color[i*CH_W +: CH_W];
                q1  = first_weight;
                p2  = second_color[i*CH_W +: CH_W];
                q2  = second_weight;
                dvs = wsum;
            end
            else if (i == LANE_A)
            begin
                // alpha product over the constant 255
                p1  = CH_MAX - a_orig;
                q1  = WGT_W'(CH_MAX - a_new);
                p2  = '0;
                q2  = '0;
                dvs = DIV_W'(CH_MAX);
            end
            else
            begin
                p1  = first_color[i*CH_W +: CH_W];
                q1  = WGT_W'(CH_MAX - a_new);
                p2  = second_color[i*CH_W +: CH_W];
                q2  = WGT_W'(a_new);
                dvs = DIV_W'(CH_MAX);
            end
        end

        awb_lane u_lane (
            .clk (clk),
            .ctl (ctl),
            .p1  (p1),
            .q1  (q1),
            .p2  (p2),
            .q2  (q2),
            .dvs (dvs),
            .quo (lane_quo[i])
        );
    end

    awb_merge u_merge (
        .clk           (clk),
        .ctl           (ctl),
        .last_tag      (last_tag),
        .lane_quo      (lane_quo),
        .blended_color (blended_color),
        .zero_weight   (zero_weight)
    );

    // The front only backs up when the whole pipe is full and held
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (res_valid && res_stall))
        else $error("input stalled while output free");

    // An empty weight sum gives a black result
    a_zero_forces_black: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && zero_weight) |-> (blended_color == '0))
        else $error("zero weight result not cleared");

endmodule
